// ===== hdl/mwc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MWC picker package
// Shared types, operation codes and constants for the multiply-with-carry
// random range picker and its bit-serial arithmetic lanes.
// ----------------------------------------------------------------------------
package mwc_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned HALF_W = 16;

  // Full scale of a probability test.
  localparam int unsigned PROB_SCALE = 1000;
  localparam logic [WORD_W-1:0] PROB_FULL = WORD_W'(PROB_SCALE);
  localparam logic [WORD_W-1:0] PROB_HALF = WORD_W'(PROB_SCALE / 2);

  // Seeding multipliers and the multiply-with-carry factors of each half.
  localparam logic [WORD_W-1:0] MUL_W = 32'd2019164533;
  localparam logic [WORD_W-1:0] MUL_Z = 32'd1000632769;
  localparam logic [WORD_W-1:0] MWC_Z = 32'd36969;
  localparam logic [WORD_W-1:0] MWC_W = 32'd18000;

  // Bit-serial step counts.
  localparam int unsigned SEED_STEPS = WORD_W;
  localparam int unsigned ADV_STEPS  = HALF_W;
  localparam int unsigned DIV_STEPS  = WORD_W;
  localparam int unsigned CNT_W      = $clog2(WORD_W);

  typedef enum logic [2:0] {
    FN_RESEED = 3'd0,
    FN_RAW    = 3'd1,
    FN_RANGE  = 3'd2,
    FN_PROB   = 3'd3,
    FN_COIN   = 3'd4
  } func_t;

  typedef struct packed {
    logic [2:0]        func;
    logic [WORD_W-1:0] range_low;
    logic [WORD_W-1:0] range_high;
    logic [9:0]        probability;
  } cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              hit;
    logic              error;
  } rsp_t;

  // Control of a bit-serial lane: load operands, or run one step.
  typedef struct packed {
    logic load;
    logic run;
  } lane_ctrl_t;

endpackage

// ===== hdl/mwc_mul_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MWC serial multiply lane
// Shift-and-add multiplier taking one multiplier bit per cycle while run is
// set. The accumulator also holds one generator half between operations.
// ----------------------------------------------------------------------------
module mwc_mul_lane (
  input  logic                      clk,
  input  mwc_pkg::lane_ctrl_t       ctrl,
  input  logic [mwc_pkg::WORD_W-1:0] acc_init,
  input  logic [mwc_pkg::WORD_W-1:0] mcand,
  input  logic [mwc_pkg::WORD_W-1:0] mplier,
  output logic [mwc_pkg::WORD_W-1:0] product
);
  import mwc_pkg::*;

  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] a;
  logic [WORD_W-1:0] b;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      acc <= acc_init;
      a   <= mcand;
      b   <= mplier;
    end else if (ctrl.run) begin
      if (b[0]) begin
        acc <= acc + a;
      end
      a <= {a[WORD_W-2:0], 1'b0};
      b <= {1'b0, b[WORD_W-1:1]};
    end
  end

  assign product = acc;

endmodule

// ===== hdl/mwc_rem_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MWC serial remainder unit
// Restoring division producing one quotient bit per cycle while run is set;
// only the remainder is kept.
// ----------------------------------------------------------------------------
module mwc_rem_unit (
  input  logic                       clk,
  input  mwc_pkg::lane_ctrl_t        ctrl,
  input  logic [mwc_pkg::WORD_W-1:0] dividend,
  input  logic [mwc_pkg::WORD_W-1:0] divisor,
  output logic [mwc_pkg::WORD_W-1:0] remainder
);
  import mwc_pkg::*;

  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] dvd;
  logic [WORD_W-1:0] dsr;
  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   diff;

  // The partial remainder stays below the divisor, so the shifted value
  // fits in one extra bit.
  assign shifted = {rem, dvd[WORD_W-1]};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem <= '0;
      dvd <= dividend;
      dsr <= divisor;
    end else if (ctrl.run) begin
      rem <= diff[WORD_W] ? shifted[WORD_W-1:0] : diff[WORD_W-1:0];
      dvd <= {dvd[WORD_W-2:0], 1'b0};
    end
  end

  assign remainder = rem;

endmodule

// ===== hdl/mwc_random_range_picker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiply-with-carry random range picker
// Two 32-bit multiply-with-carry halves serve raw words, inclusive range
// picks, probability tests and coin flips; a reseed reloads them from the
// seed register.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                         Direction  Carries
//  -------   ------------------------------  ---------  ------------------------
//  cmd       cmd_valid, cmd_stall, cmd       in         one request item
//  rsp       rsp_valid, rsp_stall, rsp       out        one result item each
//  seed      seed_wr_en, seed_wr_data        in         seed register write
//
// A raw word goes from acceptance through the serial advance, one bit of
// each half's low 16 bits a cycle, to the finishing state, which registers
// the result. Range picks, probability tests and coin flips add a load
// step and the serial remainder unit before the finishing state. A reseed
// runs the serial seeding multiply, a load step and the advance, then
// finishes. A reversed range or an unused code goes from acceptance
// straight to the finishing state. The block returns to idle as the result
// is registered, and only there takes the next item.
// After reset the block runs a reseed from seed zero and holds cmd_stall
// high meanwhile; seed writes are taken at any time.
// A finished result waits in the output register while rsp_stall is high;
// the next item is already accepted and held back only at its final step.
// ----------------------------------------------------------------------------
module mwc_random_range_picker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_stall,
  input  mwc_pkg::cmd_t              cmd,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output mwc_pkg::rsp_t              rsp,
  input  logic                       seed_wr_en,
  input  logic [mwc_pkg::WORD_W-1:0] seed_wr_data
);
  import mwc_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_RESEED_RUN,
    ST_ADV_LOAD,
    ST_ADV_RUN,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_FINISH
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  cnt;
  logic              init_run;
  logic [WORD_W-1:0] seed;
  logic [2:0]        op;
  logic              err;
  logic [WORD_W-1:0] lo;
  logic [WORD_W-1:0] span;
  logic [WORD_W-1:0] thresh;

  logic              accept;
  logic              reversed;
  logic              adv_func;
  logic              load_seed;
  logic              load_adv;
  logic              out_free;
  logic [WORD_W-1:0] seed_eff;
  logic [WORD_W-1:0] lo_c;
  logic [WORD_W-1:0] hi_c;
  logic [WORD_W-1:0] span_c;
  logic [WORD_W-1:0] z_half;
  logic [WORD_W-1:0] w_half;
  logic [WORD_W-1:0] word;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] z_acc_init;
  logic [WORD_W-1:0] z_mcand;
  logic [WORD_W-1:0] z_mplier;
  logic [WORD_W-1:0] w_acc_init;
  logic [WORD_W-1:0] w_mcand;
  logic [WORD_W-1:0] w_mplier;
  lane_ctrl_t        mul_ctrl;
  lane_ctrl_t        div_ctrl;
  rsp_t              rsp_next;

  // Requests are taken only from the idle state; everything else is busy.
  assign cmd_stall = (state != ST_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  // A reversed range reports an error and leaves the generator alone.
  assign reversed = (cmd.range_low > cmd.range_high);
  assign adv_func = (cmd.func == FN_RAW) || ((cmd.func == FN_RANGE) && !reversed) ||
                    (cmd.func == FN_PROB) || (cmd.func == FN_COIN);

  // All-ones bounds are lowered by one so the span never wraps to zero.
  assign lo_c   = (cmd.range_low == '1) ? (cmd.range_low - 1'b1) : cmd.range_low;
  assign hi_c   = (cmd.range_high == '1) ? (cmd.range_high - 1'b1) : cmd.range_high;
  assign span_c = hi_c - lo_c + 1'b1;

  // Lane loads: seeding multiply or one generator advance. The advance
  // starts straight from acceptance since the halves are already settled.
  assign load_seed = (state == ST_INIT) || (accept && (cmd.func == FN_RESEED));
  assign load_adv  = (state == ST_ADV_LOAD) || (accept && adv_func);
  assign mul_ctrl.load = load_seed || load_adv;
  assign mul_ctrl.run  = (state == ST_RESEED_RUN) || (state == ST_ADV_RUN);

  assign seed_eff = init_run ? '0 : seed;

  always_comb begin
    if (load_adv) begin
      // half = factor * (half mod 2^16) + (half div 2^16)
      z_acc_init = {{HALF_W{1'b0}}, z_half[WORD_W-1:HALF_W]};
      z_mcand    = MWC_Z;
      z_mplier   = {{HALF_W{1'b0}}, z_half[HALF_W-1:0]};
      w_acc_init = {{HALF_W{1'b0}}, w_half[WORD_W-1:HALF_W]};
      w_mcand    = MWC_W;
      w_mplier   = {{HALF_W{1'b0}}, w_half[HALF_W-1:0]};
    end else begin
      // Seeding: multiply an odd form of the seed (or its complement).
      z_acc_init = '0;
      z_mcand    = MUL_Z;
      z_mplier   = {~seed_eff[WORD_W-2:0], 1'b1};
      w_acc_init = '0;
      w_mcand    = MUL_W;
      w_mplier   = {seed_eff[WORD_W-2:0], 1'b1};
    end
  end

  mwc_mul_lane u_lane_z (
    .clk      (clk),
    .ctrl     (mul_ctrl),
    .acc_init (z_acc_init),
    .mcand    (z_mcand),
    .mplier   (z_mplier),
    .product  (z_half)
  );

  mwc_mul_lane u_lane_w (
    .clk      (clk),
    .ctrl     (mul_ctrl),
    .acc_init (w_acc_init),
    .mcand    (w_mcand),
    .mplier   (w_mplier),
    .product  (w_half)
  );

  // The generator output word combines both halves.
  assign word = {z_half[HALF_W-1:0], {HALF_W{1'b0}}} + w_half;

  assign div_ctrl.load = (state == ST_DIV_LOAD);
  assign div_ctrl.run  = (state == ST_DIV_RUN);

  mwc_rem_unit u_rem (
    .clk       (clk),
    .ctrl      (div_ctrl),
    .dividend  (word),
    .divisor   (span),
    .remainder (rem)
  );

  // Result assembly for the finished operation.
  always_comb begin
    rsp_next = '0;
    unique case (op)
      FN_RAW: begin
        rsp_next.value = word;
      end
      FN_RANGE: begin
        rsp_next.error = err;
        if (!err) begin
          rsp_next.value = rem + lo;
        end
      end
      FN_PROB, FN_COIN: begin
        rsp_next.hit = (rem < thresh);
      end
      default: begin
        rsp_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      cnt       <= '0;
      init_run  <= 1'b1;
      seed      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (seed_wr_en) begin
        seed <= seed_wr_data;
      end
      // The finishing state sets valid itself when the register frees up.
      if (rsp_valid && !rsp_stall && (state != ST_FINISH)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_INIT: begin
          cnt   <= '0;
          state <= ST_RESEED_RUN;
        end
        ST_IDLE: begin
          if (accept) begin
            op  <= cmd.func;
            err <= (cmd.func == FN_RANGE) && reversed;
            cnt <= '0;
            if (cmd.func == FN_RANGE) begin
              lo   <= lo_c;
              span <= span_c;
            end else begin
              lo   <= '0;
              span <= PROB_FULL;
            end
            thresh <= (cmd.func == FN_COIN) ? PROB_HALF
                                            : {{(WORD_W-10){1'b0}}, cmd.probability};
            if (cmd.func == FN_RESEED) begin
              state <= ST_RESEED_RUN;
            end else if (adv_func) begin
              state <= ST_ADV_RUN;
            end else begin
              state <= ST_FINISH;
            end
          end
        end
        ST_RESEED_RUN: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(SEED_STEPS - 1)) begin
            state <= ST_ADV_LOAD;
          end
        end
        ST_ADV_LOAD: begin
          cnt   <= '0;
          state <= ST_ADV_RUN;
        end
        ST_ADV_RUN: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(ADV_STEPS - 1)) begin
            if (init_run) begin
              init_run <= 1'b0;
              state    <= ST_IDLE;
            end else if ((op == FN_RANGE) || (op == FN_PROB) || (op == FN_COIN)) begin
              state <= ST_DIV_LOAD;
            end else begin
              state <= ST_FINISH;
            end
          end
        end
        ST_DIV_LOAD: begin
          cnt   <= '0;
          state <= ST_DIV_RUN;
        end
        ST_DIV_RUN: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // Hold here until the output register is free.
          if (out_free) begin
            rsp       <= rsp_next;
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
